### rtl/dtm_pkg.sv
// ----------------------------------------------------------------------------
// dtm_pkg
// character codes and scale constants shared by the duration text parser
// ----------------------------------------------------------------------------
`default_nettype none

package dtm_pkg;

  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_COLON = 8'h3a;
  localparam logic [7:0] CHAR_DOT   = 8'h2e;
  localparam logic [7:0] CHAR_COMMA = 8'h2c;

  localparam int DEC_BASE     = 10;
  localparam int SEC_PER_MIN  = 60;
  localparam int MS_PER_SEC   = 1000;
  localparam int FRAC_SCALE_1 = 100;
  localparam int FRAC_SCALE_2 = 10;

  localparam logic [2:0] FRAC_DIGITS_MAX = 3'd7;
  localparam logic [1:0] FIELDS_MAX      = 2'd2;

  localparam int OUT_WIDTH = 32;

endpackage

`default_nettype wire

### rtl/dtm_parse.sv
// ----------------------------------------------------------------------------
// dtm_parse
// input register and per-character parse state, snapshot on the last item
// ----------------------------------------------------------------------------
`default_nettype none

module dtm_parse #(
  parameter int W = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [7:0]   s_tdata,
  input  wire logic         s_tlast,
  output logic              snap_valid,
  input  wire logic         snap_ready,
  output logic [W-1:0]      snap_fields,
  output logic [W-1:0]      snap_cur,
  output logic [W-1:0]      snap_frac,
  output logic [2:0]        snap_digits,
  output logic              snap_seen
);

  typedef enum logic [1:0] {
    PH_INT,
    PH_COLON,
    PH_FRAC,
    PH_STOP
  } phase_t;

  logic         in_valid;
  logic [7:0]   in_byte;
  logic         in_last;
  logic         in_go;
  logic         snap_free;

  logic [W-1:0] fields;
  logic [W-1:0] cur;
  logic [1:0]   count;
  logic [W-1:0] frac;
  logic [2:0]   digits;
  phase_t       phase;
  logic         seen;

  logic [W-1:0] fields_next;
  logic [W-1:0] cur_next;
  logic [1:0]   count_next;
  logic [W-1:0] frac_next;
  logic [2:0]   digits_next;
  phase_t       phase_next;
  logic         seen_next;

  logic         is_digit;
  logic         is_point;
  logic [W-1:0] dval;

  assign snap_free = !snap_valid || snap_ready;
  assign in_go     = in_valid && (!in_last || snap_free);
  assign s_tready  = !in_valid || in_go;

  assign is_digit = (in_byte >= dtm_pkg::CHAR_0) && (in_byte <= dtm_pkg::CHAR_9);
  assign is_point = (in_byte == dtm_pkg::CHAR_DOT) || (in_byte == dtm_pkg::CHAR_COMMA);
  assign dval     = is_digit ? W'(in_byte[3:0]) : '0;

  always_comb begin
    fields_next = fields;
    cur_next    = cur;
    count_next  = count;
    frac_next   = frac;
    digits_next = digits;
    phase_next  = phase;
    seen_next   = seen;
    case (phase)
      PH_INT: begin
        if (is_digit) begin
          cur_next  = W'(cur * W'(dtm_pkg::DEC_BASE)) + dval;
          seen_next = 1'b1;
        end else if (!seen) begin
          phase_next = PH_STOP;
        end else if (in_byte == dtm_pkg::CHAR_COLON && count < dtm_pkg::FIELDS_MAX) begin
          phase_next = PH_COLON;
        end else if (is_point) begin
          phase_next = PH_FRAC;
        end else begin
          phase_next = PH_STOP;
        end
      end
      PH_COLON: begin
        if (is_digit) begin
          fields_next = W'(fields * W'(dtm_pkg::SEC_PER_MIN)) + cur;
          cur_next    = dval;
          count_next  = count + 2'd1;
          phase_next  = PH_INT;
        end else begin
          phase_next = PH_STOP;
        end
      end
      PH_FRAC: begin
        if (is_digit) begin
          frac_next = W'(frac * W'(dtm_pkg::DEC_BASE)) + dval;
          if (digits != dtm_pkg::FRAC_DIGITS_MAX) begin
            digits_next = digits + 3'd1;
          end
        end else begin
          phase_next = PH_STOP;
        end
      end
      default: begin
        phase_next = PH_STOP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      snap_valid <= 1'b0;
      fields     <= '0;
      cur        <= '0;
      count      <= '0;
      frac       <= '0;
      digits     <= '0;
      phase      <= PH_INT;
      seen       <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (in_go && in_last) begin
        snap_valid <= 1'b1;
      end else if (snap_ready) begin
        snap_valid <= 1'b0;
      end
      if (in_go) begin
        if (in_last) begin
          fields <= '0;
          cur    <= '0;
          count  <= '0;
          frac   <= '0;
          digits <= '0;
          phase  <= PH_INT;
          seen   <= 1'b0;
        end else begin
          fields <= fields_next;
          cur    <= cur_next;
          count  <= count_next;
          frac   <= frac_next;
          digits <= digits_next;
          phase  <= phase_next;
          seen   <= seen_next;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
    if (in_go && in_last) begin
      snap_fields <= fields_next;
      snap_cur    <= cur_next;
      snap_frac   <= frac_next;
      snap_digits <= digits_next;
      snap_seen   <= seen_next;
    end
  end

endmodule

`default_nettype wire

### rtl/dtm_total.sv
// ----------------------------------------------------------------------------
// dtm_total
// two-stage millisecond total and output register
// ----------------------------------------------------------------------------
`default_nettype none

module dtm_total #(
  parameter int W = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           snap_valid,
  output logic                                snap_ready,
  input  wire logic [W-1:0]                   snap_fields,
  input  wire logic [W-1:0]                   snap_cur,
  input  wire logic [W-1:0]                   snap_frac,
  input  wire logic [2:0]                     snap_digits,
  input  wire logic                           snap_seen,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [dtm_pkg::OUT_WIDTH-1:0]       m_tdata,
  output logic                                m_tuser
);

  logic         sum_valid;
  logic [W-1:0] secs;
  logic [W-1:0] frac_ms;
  logic         sum_seen;
  logic         sum_ready;
  logic         out_free;

  logic [W-1:0] frac_scaled;
  logic [W-1:0] total;

  assign out_free   = !m_tvalid || m_tready;
  assign sum_ready  = !sum_valid || out_free;
  assign snap_ready = sum_ready;

  always_comb begin
    case (snap_digits)
      3'd0:    frac_scaled = '0;
      3'd1:    frac_scaled = W'(snap_frac * W'(dtm_pkg::FRAC_SCALE_1));
      3'd2:    frac_scaled = W'(snap_frac * W'(dtm_pkg::FRAC_SCALE_2));
      default: frac_scaled = snap_frac;
    endcase
  end

  assign total = W'(secs * W'(dtm_pkg::MS_PER_SEC)) + frac_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (sum_ready) begin
        sum_valid <= snap_valid;
      end
      if (out_free) begin
        m_tvalid <= sum_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (snap_valid && sum_ready) begin
      secs     <= W'(snap_fields * W'(dtm_pkg::SEC_PER_MIN)) + snap_cur;
      frac_ms  <= frac_scaled;
      sum_seen <= snap_seen;
    end
    if (sum_valid && out_free) begin
      m_tdata <= dtm_pkg::OUT_WIDTH'(total);
      m_tuser <= sum_seen;
    end
  end

endmodule

`default_nettype wire

### rtl/duration_text_to_ms.sv
// ----------------------------------------------------------------------------
// duration_text_to_ms
// converts [[h:]m:]s[.fff] text, one character per item, to milliseconds
// ----------------------------------------------------------------------------
//  channel  dir  handshake          contents
//  s_*      in   tvalid / tready    tdata[7:0] char_byte, tlast last
//  m_*      out  tvalid / tready    tdata[31:0] duration_ms, tuser matched
//
//  one character per cycle unless a last character stalls; the parse state takes one update per item
//  a string's result passes the snapshot, sum and output registers after its last character is taken
//  rst is synchronous and clears the parse state and all valid flags
//  up to three results can wait on m_tready; a further last character then
//  stalls in the input register and holds back all input behind it
// ----------------------------------------------------------------------------
`default_nettype none

module duration_text_to_ms #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [7:0]                  s_tdata,  // [7:0] char_byte
  input  wire logic                        s_tlast,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [dtm_pkg::OUT_WIDTH-1:0]    m_tdata,  // [31:0] duration_ms
  output logic                             m_tuser   // [0] matched
);

  logic                   snap_valid;
  logic                   snap_ready;
  logic [VALUE_WIDTH-1:0] snap_fields;
  logic [VALUE_WIDTH-1:0] snap_cur;
  logic [VALUE_WIDTH-1:0] snap_frac;
  logic [2:0]             snap_digits;
  logic                   snap_seen;

  dtm_parse #(
    .W (VALUE_WIDTH)
  ) u_parse (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .snap_valid  (snap_valid),
    .snap_ready  (snap_ready),
    .snap_fields (snap_fields),
    .snap_cur    (snap_cur),
    .snap_frac   (snap_frac),
    .snap_digits (snap_digits),
    .snap_seen   (snap_seen)
  );

  dtm_total #(
    .W (VALUE_WIDTH)
  ) u_total (
    .clk         (clk),
    .rst         (rst),
    .snap_valid  (snap_valid),
    .snap_ready  (snap_ready),
    .snap_fields (snap_fields),
    .snap_cur    (snap_cur),
    .snap_frac   (snap_frac),
    .snap_digits (snap_digits),
    .snap_seen   (snap_seen),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

endmodule

`default_nettype wire

### test/duration_text_to_ms_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// duration_text_to_ms_checker
// watches both streams of the duration parser, keeps its own copy of the
// parse state, works out the millisecond total for every string and compares
// each outgoing result, field by field, with the oldest total still owed
// ----------------------------------------------------------------------------
module duration_text_to_ms_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] char_byte
  input  logic                          s_tlast,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [dtm_pkg::OUT_WIDTH-1:0] m_tdata,   // [31:0] duration_ms
  input  logic                          m_tuser,   // [0] matched
  output int                            fail_count,
  output int                            pending_count,
  output int                            result_count
);

  typedef enum logic [1:0] {
    PH_WHOLE,
    PH_AFTER_COLON,
    PH_FRACTION,
    PH_HALTED
  } parse_phase_t;

  typedef struct packed {
    logic [dtm_pkg::OUT_WIDTH-1:0] duration_ms;
    logic                          matched;
  } duration_t;

  logic [31:0]  fields_b60;
  logic [31:0]  field_value;
  logic [1:0]   fields_done;
  logic [31:0]  frac_value;
  logic [2:0]   frac_digits;
  parse_phase_t phase;
  logic         lead_digit;
  duration_t    owed_durations[$];

  task automatic clear_parse();
    fields_b60  = '0;
    field_value = '0;
    fields_done = '0;
    frac_value  = '0;
    frac_digits = '0;
    phase       = PH_WHOLE;
    lead_digit  = 1'b0;
  endtask

  task automatic log_mismatch(input string what, input duration_t want, input duration_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t: %s: expected ms=%0d matched=%0b, got ms=%0d matched=%0b",
               $time, what, want.duration_ms, want.matched, got.duration_ms, got.matched);
    end
  endtask

  always @(posedge clk) begin
    logic        is_digit;
    logic [31:0] digit;
    logic [31:0] frac_scale;
    logic [31:0] secs;
    duration_t   due;
    duration_t   got;
    duration_t   want;
    if (rst) begin
      clear_parse();
      owed_durations.delete();
      fail_count   = 0;
      result_count = 0;
    end else begin
      // a result always leaves after its last character was taken, so check first
      if (m_tvalid && m_tready) begin
        got = '{duration_ms: m_tdata, matched: m_tuser};
        result_count++;
        if (owed_durations.size() == 0) begin
          log_mismatch("result with nothing owed", '0, got);
        end else begin
          want = owed_durations.pop_front();
          if (got.duration_ms !== want.duration_ms || got.matched !== want.matched) begin
            log_mismatch("wrong result", want, got);
          end
        end
      end

      if (s_tvalid && s_tready) begin
        is_digit = s_tdata >= dtm_pkg::CHAR_0 && s_tdata <= dtm_pkg::CHAR_9;
        digit    = {24'd0, s_tdata - dtm_pkg::CHAR_0};
        case (phase)
          PH_WHOLE: begin
            if (is_digit) begin
              field_value = field_value * dtm_pkg::DEC_BASE + digit;
              lead_digit  = 1'b1;
            end else if (!lead_digit) begin
              phase = PH_HALTED;
            end else if (s_tdata == dtm_pkg::CHAR_COLON
                         && fields_done < dtm_pkg::FIELDS_MAX) begin
              phase = PH_AFTER_COLON;
            end else if (s_tdata == dtm_pkg::CHAR_DOT || s_tdata == dtm_pkg::CHAR_COMMA) begin
              phase = PH_FRACTION;
            end else begin
              phase = PH_HALTED;
            end
          end
          PH_AFTER_COLON: begin
            if (is_digit) begin
              fields_b60  = fields_b60 * dtm_pkg::SEC_PER_MIN + field_value;
              field_value = digit;
              fields_done = fields_done + 2'd1;
              phase       = PH_WHOLE;
            end else begin
              phase = PH_HALTED;
            end
          end
          PH_FRACTION: begin
            if (is_digit) begin
              frac_value = frac_value * dtm_pkg::DEC_BASE + digit;
              if (frac_digits < dtm_pkg::FRAC_DIGITS_MAX) frac_digits = frac_digits + 3'd1;
            end else begin
              phase = PH_HALTED;
            end
          end
          default: ;
        endcase

        if (s_tlast) begin
          case (frac_digits)
            3'd0:    frac_scale = 32'd0;
            3'd1:    frac_scale = dtm_pkg::FRAC_SCALE_1;
            3'd2:    frac_scale = dtm_pkg::FRAC_SCALE_2;
            default: frac_scale = 32'd1;
          endcase
          secs            = fields_b60 * dtm_pkg::SEC_PER_MIN + field_value;
          due.duration_ms = secs * dtm_pkg::MS_PER_SEC + frac_value * frac_scale;
          due.matched     = lead_digit;
          owed_durations.push_back(due);
          clear_parse();
        end
      end
    end
    pending_count <= owed_durations.size();
  end

endmodule

### test/duration_text_to_ms_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// duration_text_to_ms_tb
// feeds duration strings into the parser one character per item: a few
// hand-picked strings first, then random well-formed times with random
// corruption and plain noise, under changing input gaps and output stalls;
// the checker beside the block predicts and compares every total
// ----------------------------------------------------------------------------
module duration_text_to_ms_tb;

  localparam int ITEM_TARGET   = 850;
  localparam int PHASES        = 5;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT   = 400000;

  logic                          clk      = 1'b0;
  logic                          rst      = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [7:0]                    s_tdata  = 8'h00;  // [7:0] char_byte
  logic                          s_tlast  = 1'b0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [dtm_pkg::OUT_WIDTH-1:0] m_tdata;           // [31:0] duration_ms
  logic                          m_tuser;           // [0] matched

  int   fail_count;
  int   pending_count;
  int   result_count;
  int   send_idle_pct = 0;
  int   stall_pct     = 0;
  logic hold_off      = 1'b0;
  int   cycle_count   = 0;
  int   char_count    = 0;
  int   text_count    = 0;
  logic [7:0] text_q[$];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  duration_text_to_ms u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  duration_text_to_ms_checker u_checker (.*);

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count, pending_count);
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst || hold_off) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= $urandom_range(99) >= stall_pct;
    end
  end

  task automatic send_char(input logic [7:0] c, input logic is_last);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= is_last;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_char(text_q[i], i == text_q.size() - 1);
    text_count++;
  endtask

  function automatic void add_digits(input int n);
    repeat (n) text_q.push_back(dtm_pkg::CHAR_0 + 8'($urandom_range(9)));
  endfunction

  function automatic logic [7:0] pick_odd_char();
    case ($urandom_range(3))
      0:       return dtm_pkg::CHAR_COLON;
      1:       return $urandom_range(1) ? dtm_pkg::CHAR_DOT : dtm_pkg::CHAR_COMMA;
      2:       return dtm_pkg::CHAR_0 + 8'($urandom_range(9));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // builds the next string in text_q, returns how many of its characters count
  function automatic int make_text();
    int fields;
    int counted;
    text_q.delete();
    if ($urandom_range(99) < 78) begin
      fields = $urandom_range(1, 3);
      for (int f = 0; f < fields; f++) begin
        if (f != 0) text_q.push_back(dtm_pkg::CHAR_COLON);
        add_digits($urandom_range(9) == 0 ? $urandom_range(4, 11) : $urandom_range(1, 2));
      end
      if ($urandom_range(2) != 0) begin
        text_q.push_back($urandom_range(1) ? dtm_pkg::CHAR_DOT : dtm_pkg::CHAR_COMMA);
        add_digits($urandom_range(7) == 0 ? $urandom_range(4, 9) : $urandom_range(0, 3));
      end
      counted = text_q.size();
      case ($urandom_range(9))
        0:       text_q[$urandom_range(text_q.size() - 1)] = pick_odd_char();
        // trailing junk is appended uncounted; a digit, colon or point in it can still change the result
        1:       repeat ($urandom_range(1, 3)) text_q.push_back(pick_odd_char());
        default: ;
      endcase
    end else begin
      repeat ($urandom_range(1, 6)) text_q.push_back(pick_odd_char());
      counted = text_q.size();
    end
    return counted;
  endfunction

  initial begin
    string directed[6] = '{"1:2:3.5", "2,25", "3:.", "1:2:3:4", "5.", "9.1234"};
    int    idle_by_phase[PHASES]  = '{0, 55, 0, 12, 0};
    int    stall_by_phase[PHASES] = '{0, 0, 55, 12, 0};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[k]) begin
      text_q.delete();
      for (int i = 0; i < directed[k].len(); i++) text_q.push_back(directed[k][i]);
      char_count += text_q.size();
      send_text();
    end
    text_q = '{8'hff};
    send_text();
    text_q = '{8'h00};
    send_text();
    char_count += 2;

    for (int ph = 0; ph < PHASES; ph++) begin
      send_idle_pct = idle_by_phase[ph];
      stall_pct    <= stall_by_phase[ph];
      if (ph == PHASES - 1) begin
        fork
          begin
            hold_off <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_off <= 1'b0;
          end
        join_none
      end
      while (char_count < (ph + 1) * ITEM_TARGET / PHASES) begin
        char_count += make_text();
        send_text();
      end
    end

    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d strings (%0d counted characters) gave %0d results, all compared",
             text_count, char_count, result_count);
    $display("idling phases: none, input gaps, output stalls, both, then a %0d-cycle hold-off",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
rtl/dtm_pkg.sv
rtl/dtm_parse.sv
rtl/dtm_total.sv
rtl/duration_text_to_ms.sv
test/duration_text_to_ms_checker.sv
test/duration_text_to_ms_tb.sv
